// File: hw/rtl/cnms_pkg.sv
// ============================================================================
// cnms_pkg
// Shared constants and helpers for the Canny non-maximum suppression block.
// ============================================================================
package cnms_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int DERIV_BITS_DEF = 16;
   localparam int MAG_BITS_DEF   = 16;

   localparam int CSR_DATA_BITS = 11;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [CSR_DATA_BITS-1:0] IMAGE_WIDTH_RESET  = 11'd640;
   localparam logic [CSR_DATA_BITS-1:0] IMAGE_HEIGHT_RESET = 11'd480;

   // Clamp a dimension register to [3, maxv].
   function automatic int clamp_dim(logic [CSR_DATA_BITS-1:0] v, int maxv);
      int r;
      r = int'(v);
      if (r < 3) r = 3;
      if (r > maxv) r = maxv;
      return r;
   endfunction

endpackage

// File: hw/rtl/canny_nonmax_suppression.sv
// ============================================================================
// canny_nonmax_suppression
// Raster-stream non-maximum suppression over a 3x3 gradient magnitude window.
// ============================================================================
//  channel | ports                         | direction
//  req     | req_valid/req_ready + fields  | in, one pixel per transfer
//  rsp     | rsp_valid/rsp_ready + fields  | out, one center per transfer
//  csr     | csr_wr_en, csr_index, wdata   | in, write only
//
// One pixel per cycle sustained unless the output stalls.
// One line memory (two magnitude rows plus one derivative row) is read at the
// pixel's column and written back as that pixel leaves stage 1; columns of
// neighboring pixels always differ, so no forwarding is needed.
// A full pipeline stalls as a whole while rsp_valid is high and rsp_ready low.
// Reset clears counters and valids; memory contents are not cleared.
module canny_nonmax_suppression #(
   parameter int MAX_WIDTH  = cnms_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = cnms_pkg::MAX_HEIGHT_DEF,
   parameter int DERIV_BITS = cnms_pkg::DERIV_BITS_DEF,
   parameter int MAG_BITS   = cnms_pkg::MAG_BITS_DEF,
   localparam int CW        = $clog2(MAX_WIDTH),
   localparam int RW        = $clog2(MAX_HEIGHT)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [DERIV_BITS-1:0]          req_x_deriv,
   input  logic signed [DERIV_BITS-1:0]          req_y_deriv,
   input  logic        [MAG_BITS-1:0]            req_magnitude,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic        [MAG_BITS-1:0]            rsp_out_magnitude,
   output logic        [RW-1:0]                  rsp_out_row,
   output logic        [CW-1:0]                  rsp_out_col,
   output logic                                  rsp_last,
   input  logic                                  csr_wr_en,
   input  cnms_pkg::csr_index_type               csr_index,
   input  logic        [cnms_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int LW = 2 * MAG_BITS + 2 * DERIV_BITS;
   localparam int PW = DERIV_BITS + MAG_BITS + 4;

   // ---------------- configuration ----------------
   logic [cnms_pkg::CSR_DATA_BITS-1:0] width_ff, height_ff;
   logic [CW-1:0] wm1;
   logic [RW-1:0] hm1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= cnms_pkg::IMAGE_WIDTH_RESET;
         height_ff <= cnms_pkg::IMAGE_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            cnms_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            cnms_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign wm1 = CW'(cnms_pkg::clamp_dim(width_ff, MAX_WIDTH) - 1);
   assign hm1 = RW'(cnms_pkg::clamp_dim(height_ff, MAX_HEIGHT) - 1);

   // ---------------- handshake ----------------
   logic rsp_valid_ff;
   logic en, acc;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign acc       = req_valid && en;

   // ---------------- counters ----------------
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (acc) begin
         if (col_ff >= wm1) begin
            col_ff <= '0;
            row_ff <= (row_ff >= hm1) ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // ---------------- stage 1: line memory read ----------------
   logic                         s1_valid_ff, s1_emit_ff, s1_inter_ff, s1_last_ff;
   logic [CW-1:0]                s1_col_ff;
   logic [RW-1:0]                s1_row_ff;
   logic [MAG_BITS-1:0]          s1_mag_ff;
   logic signed [DERIV_BITS-1:0] s1_dx_ff, s1_dy_ff;
   logic [LW-1:0]                line_mem [MAX_WIDTH];
   logic [LW-1:0]                mem_q_ff;
   logic [MAG_BITS-1:0]          up1, up2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_mag_ff   <= req_magnitude;
         s1_dx_ff    <= req_x_deriv;
         s1_dy_ff    <= req_y_deriv;
         s1_emit_ff  <= (row_ff >= RW'(1)) && (col_ff >= CW'(1));
         s1_inter_ff <= (row_ff >= RW'(2)) && (col_ff >= CW'(2));
         s1_last_ff  <= (row_ff == hm1) && (col_ff == wm1);
         mem_q_ff    <= line_mem[col_ff];
      end
      // write back: newest row, row above moves down, derivatives of this pixel
      if (s1_valid_ff && en)
         line_mem[s1_col_ff] <= {s1_mag_ff, mem_q_ff[LW-1 -: MAG_BITS], s1_dx_ff, s1_dy_ff};
   end

   assign up1 = mem_q_ff[LW-1 -: MAG_BITS];
   assign up2 = mem_q_ff[LW-MAG_BITS-1 -: MAG_BITS];

   // ---------------- window and center derivatives ----------------
   logic [MAG_BITS-1:0]          win_ff [3][3];
   logic [MAG_BITS-1:0]          nw [3][3];
   logic signed [DERIV_BITS-1:0] ctr_dx_ff, ctr_dy_ff;
   logic                         adv;

   assign adv = s1_valid_ff && en;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         nw[r][0] = win_ff[r][1];
         nw[r][1] = win_ff[r][2];
      end
      nw[0][2] = up2;
      nw[1][2] = up1;
      nw[2][2] = s1_mag_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         win_ff    <= nw;
         ctr_dx_ff <= mem_q_ff[2*DERIV_BITS-1 -: DERIV_BITS];
         ctr_dy_ff <= mem_q_ff[DERIV_BITS-1:0];
      end
   end

   // ---------------- stage 2: sector select ----------------
   logic                         same, ydom;
   logic [DERIV_BITS:0]          ax, ay;
   logic signed [DERIV_BITS:0]   t;
   logic signed [DERIV_BITS+1:0] q_in;
   logic signed [DERIV_BITS-1:0] d_in, p_in;
   logic [MAG_BITS-1:0]          n1_in, n2_in, n3_in, n4_in;

   always_comb begin
      same = (ctr_dx_ff > 0 && ctr_dy_ff > 0) || (ctr_dx_ff < 0 && ctr_dy_ff < 0);
      ax   = ctr_dx_ff[DERIV_BITS-1] ? (DERIV_BITS+1)'(-$signed({1'b1, ctr_dx_ff}))
                                     : (DERIV_BITS+1)'({1'b0, ctr_dx_ff});
      ay   = ctr_dy_ff[DERIV_BITS-1] ? (DERIV_BITS+1)'(-$signed({1'b1, ctr_dy_ff}))
                                     : (DERIV_BITS+1)'({1'b0, ctr_dy_ff});
      ydom = ax < ay;
      t    = same ? (DERIV_BITS+1)'(ctr_dy_ff) - (DERIV_BITS+1)'(ctr_dx_ff)
                  : (DERIV_BITS+1)'(ctr_dx_ff) + (DERIV_BITS+1)'(ctr_dy_ff);
      q_in = (same && ydom) ? (DERIV_BITS+2)'(t) : -(DERIV_BITS+2)'(t);
      d_in = ydom ? ctr_dy_ff : ctr_dx_ff;
      p_in = ydom ? ctr_dx_ff : ctr_dy_ff;
      n1_in = same ? nw[2][2] : nw[0][2];
      n3_in = same ? nw[0][0] : nw[2][0];
      n2_in = ydom ? (same ? nw[2][1] : nw[0][1]) : nw[1][2];
      n4_in = ydom ? (same ? nw[0][1] : nw[2][1]) : nw[1][0];
   end

   // center derivatives in use are the ones held before this advance
   logic signed [DERIV_BITS-1:0] s2_d_ff, s2_p_ff;
   logic signed [DERIV_BITS+1:0] s2_q_ff;
   logic [MAG_BITS-1:0]          s2_gc_ff, s2_n1_ff, s2_n2_ff, s2_n3_ff, s2_n4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_d_ff  <= d_in;
         s2_p_ff  <= p_in;
         s2_q_ff  <= q_in;
         s2_gc_ff <= nw[1][1];
         s2_n1_ff <= n1_in;
         s2_n2_ff <= n2_in;
         s2_n3_ff <= n3_in;
         s2_n4_ff <= n4_in;
      end
   end

   // ---------------- stages 3-4: products and sums ----------------
   logic [PW-1:0] g0_abs, a_abs, b_abs;

   cnms_ridge #(
      .DERIV_BITS(DERIV_BITS),
      .MAG_BITS  (MAG_BITS)
   ) u_ridge (
      .clock (clock),
      .en    (en),
      .d     (s2_d_ff),
      .p     (s2_p_ff),
      .q     (s2_q_ff),
      .gc    (s2_gc_ff),
      .n1    (s2_n1_ff),
      .n2    (s2_n2_ff),
      .n3    (s2_n3_ff),
      .n4    (s2_n4_ff),
      .g0_abs(g0_abs),
      .a_abs (a_abs),
      .b_abs (b_abs)
   );

   // ---------------- sideband for stages 2..4 ----------------
   logic                sb_valid_ff [3];
   logic                sb_inter_ff [3];
   logic                sb_last_ff  [3];
   logic [RW-1:0]       sb_row_ff   [3];
   logic [CW-1:0]       sb_col_ff   [3];
   logic [MAG_BITS-1:0] sb_mag_ff   [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) sb_valid_ff[i] <= 1'b0;
      end else if (en) begin
         sb_valid_ff[0] <= s1_valid_ff && s1_emit_ff;
         sb_valid_ff[1] <= sb_valid_ff[0];
         sb_valid_ff[2] <= sb_valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sb_inter_ff[0] <= s1_inter_ff;
         sb_last_ff[0]  <= s1_last_ff;
         sb_row_ff[0]   <= s1_row_ff - 1'b1;
         sb_col_ff[0]   <= s1_col_ff - 1'b1;
         sb_mag_ff[0]   <= nw[1][1];
         for (int i = 1; i < 3; i++) begin
            sb_inter_ff[i] <= sb_inter_ff[i-1];
            sb_last_ff[i]  <= sb_last_ff[i-1];
            sb_row_ff[i]   <= sb_row_ff[i-1];
            sb_col_ff[i]   <= sb_col_ff[i-1];
            sb_mag_ff[i]   <= sb_mag_ff[i-1];
         end
      end
   end

   // ---------------- output register ----------------
   logic                pass;
   logic [MAG_BITS-1:0] rsp_mag_ff;
   logic [RW-1:0]       rsp_row_ff;
   logic [CW-1:0]       rsp_col_ff;
   logic                rsp_last_ff;

   assign pass = !(g0_abs <= a_abs || g0_abs < b_abs);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sb_valid_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_mag_ff  <= (sb_inter_ff[2] && pass) ? sb_mag_ff[2] : '0;
         rsp_row_ff  <= sb_row_ff[2];
         rsp_col_ff  <= sb_col_ff[2];
         rsp_last_ff <= sb_last_ff[2];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_magnitude = rsp_mag_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_no_same_column_rmw: assert property (@(posedge clock) disable iff (reset)
      (acc && adv) |-> (col_ff != s1_col_ff))
      else $error("line memory read and write hit the same column");

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_out_row == '0 || rsp_out_col == '0)) |-> (rsp_out_magnitude == '0))
      else $error("border center produced a nonzero magnitude");

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_out_col == wm1 - 1'b1 && rsp_out_row == hm1 - 1'b1))
      else $error("last flag on a center other than the frame end");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(sb_valid_ff[2]) && $stable(s1_valid_ff))
      else $error("pipeline moved during output stall");
`endif

endmodule

// File: hw/rtl/cnms_ridge.sv
// ============================================================================
// cnms_ridge
// Two-stage product/sum unit: forms |d*gc|, |p*n1 + q*n2| and |p*n3 + q*n4|.
// ============================================================================
module cnms_ridge #(
   parameter int DERIV_BITS = cnms_pkg::DERIV_BITS_DEF,
   parameter int MAG_BITS   = cnms_pkg::MAG_BITS_DEF,
   localparam int PW        = DERIV_BITS + MAG_BITS + 4
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [DERIV_BITS-1:0] d,
   input  logic signed [DERIV_BITS-1:0] p,
   input  logic signed [DERIV_BITS+1:0] q,
   input  logic        [MAG_BITS-1:0]   gc,
   input  logic        [MAG_BITS-1:0]   n1,
   input  logic        [MAG_BITS-1:0]   n2,
   input  logic        [MAG_BITS-1:0]   n3,
   input  logic        [MAG_BITS-1:0]   n4,
   output logic        [PW-1:0]         g0_abs,
   output logic        [PW-1:0]         a_abs,
   output logic        [PW-1:0]         b_abs
);

   logic signed [PW-1:0] pg_ff, pa1_ff, pa2_ff, pb1_ff, pb2_ff;
   logic signed [PW-1:0] pg_in, pa1_in, pa2_in, pb1_in, pb2_in;
   logic signed [PW-1:0] sa, sb;
   logic        [PW-1:0] g0_ff, a_ff, b_ff;

   always_comb begin
      pg_in  = PW'(d) * PW'($signed({1'b0, gc}));
      pa1_in = PW'(p) * PW'($signed({1'b0, n1}));
      pa2_in = PW'(q) * PW'($signed({1'b0, n2}));
      pb1_in = PW'(p) * PW'($signed({1'b0, n3}));
      pb2_in = PW'(q) * PW'($signed({1'b0, n4}));
      sa     = pa1_ff + pa2_ff;
      sb     = pb1_ff + pb2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pg_ff  <= pg_in;
         pa1_ff <= pa1_in;
         pa2_ff <= pa2_in;
         pb1_ff <= pb1_in;
         pb2_ff <= pb2_in;
         g0_ff  <= pg_ff[PW-1] ? PW'(-pg_ff) : PW'(pg_ff);
         a_ff   <= sa[PW-1] ? PW'(-sa) : PW'(sa);
         b_ff   <= sb[PW-1] ? PW'(-sb) : PW'(sb);
      end
   end

   assign g0_abs = g0_ff;
   assign a_abs  = a_ff;
   assign b_abs  = b_ff;

endmodule
